// ----- rtl/core/d5p_pkg.sv -----
// ----------------------------------------------------------------------------
// d5p_pkg
// Shared types and constants for the dictionary 5-bit packer.
// ----------------------------------------------------------------------------
package d5p_pkg;

  localparam int CODE_BITS = 5;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_FLUSH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // top -> search unit
  typedef struct packed {
    logic       start;
    logic [7:0] ch;
    logic [5:0] dict_size;
    logic       wr_en;
    logic [4:0] wr_idx;
    logic [7:0] wr_char;
  } srch_req_t;

  // search unit -> top
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic [CODE_BITS-1:0] code;
  } srch_rsp_t;

endpackage

// ----- rtl/core/d5p_search.sv -----
// ----------------------------------------------------------------------------
// d5p_search
// Dictionary memory and linear search engine: one slot read per cycle,
// first matching slot wins.
// ----------------------------------------------------------------------------
module d5p_search #(
  parameter int DICT_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  d5p_pkg::srch_req_t req,
  output d5p_pkg::srch_rsp_t rsp
);
  import d5p_pkg::*;

  localparam int IDX_W = $clog2(DICT_ENTRIES);
  localparam int CNT_W = $clog2(DICT_ENTRIES + 1);

  logic [7:0]       mem [DICT_ENTRIES];
  logic [7:0]       rd_data_r;
  logic             rv_r;
  logic [CNT_W-1:0] ridx_r;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [CNT_W-1:0] lim_start;
  logic             hit_now;
  logic             done;
  logic             issue;

  assign lim_start = (req.dict_size > 6'(DICT_ENTRIES)) ? CNT_W'(DICT_ENTRIES)
                                                        : req.dict_size[CNT_W-1:0];
  assign hit_now   = rv_r && (rd_data_r == char_r);
  assign done      = busy_r && ((lim_r == '0) ||
                     (rv_r && (hit_now || (ridx_r == lim_r - CNT_W'(1)))));
  assign issue     = busy_r && !done && (cnt_r < lim_r);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    char_nxt = char_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      lim_nxt  = lim_start;
      char_nxt = req.ch;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rv_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rv_r   <= issue;
    end
    cnt_r  <= cnt_nxt;
    lim_r  <= lim_nxt;
    char_r <= char_nxt;
    ridx_r <= cnt_r;
  end

  // loads only arrive while no search runs, so no read/write overlap
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx[IDX_W-1:0]] <= req.wr_char;
    end
    if (issue) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
    end
  end

  // a miss codes as zero
  assign rsp.busy = busy_r;
  assign rsp.done = done;
  assign rsp.hit  = hit_now;
  assign rsp.code = hit_now ? CODE_BITS'(ridx_r[IDX_W-1:0]) : '0;

endmodule

// ----- rtl/core/dictionary_5bit_packer.sv -----
// ----------------------------------------------------------------------------
// dictionary_5bit_packer
// Replaces characters by their dictionary slot and packs the 5-bit codes
// MSB first into bytes.
// ----------------------------------------------------------------------------
// Input beat: tuser is the action (load slot, data char, flush). A load
//   writes one dictionary slot.
// A data beat searches the dictionary memory one slot per cycle from slot 0:
//   a hit in slot h ends the search there, a miss searches all
//   min(dict_size,DICT_ENTRIES) slots, and a full byte then passes through
//   the emit state. One item is in work at a time.
// A flush emits the zero-padded partial byte with tlast set.
// Output beat: tdata holds the byte and its valid bit count, tuser the
//   sticky miss flag. An output register holds the beat; while it is stalled
//   the block still takes loads and data beats that produce no byte.
// cfg_wr_en writes dict_size (slots searched); the user must write it only while idle, the block does not enforce this.
// Reset (rst_n low, synchronous): accumulator, pending count, miss flag
//   cleared, dict_size = 32. Dictionary contents are undefined until loaded.
// ----------------------------------------------------------------------------
module dictionary_5bit_packer #(
  parameter int DICT_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_index[4:0], entry_char[12:5], data_char[20:13]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // packed_byte[7:0], valid_bits[11:8]
  output logic        out_tlast,  // is_final
  output logic        out_tuser,  // miss_seen
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);
  import d5p_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] dict_size_r;
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic       miss_r, miss_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic [3:0] res_bits_r, res_bits_nxt;
  logic       res_last_r, res_last_nxt;
  logic       res_miss_r, res_miss_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [3:0] out_bits_r, out_bits_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_miss_r, out_miss_nxt;

  srch_req_t  sreq;
  srch_rsp_t  srsp;
  action_t    action;
  logic       out_free;
  logic [12:0] total;
  logic [3:0]  nbits;
  logic [2:0]  rest;
  logic [3:0]  fl_shift;
  logic        miss_upd;

  assign action   = action_t'(in_tuser);
  assign out_free = !out_tvalid_r || out_tready;
  assign total    = {acc_r, srsp.code};
  assign nbits    = {1'b0, pend_r} + 4'(CODE_BITS);
  assign rest     = 3'(nbits - 4'd8);
  assign fl_shift = 4'd8 - {1'b0, pend_r};
  assign miss_upd = miss_r | !srsp.hit;

  d5p_search #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_search (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sreq),
    .rsp  (srsp)
  );

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    miss_nxt       = miss_r;
    res_byte_nxt   = res_byte_r;
    res_bits_nxt   = res_bits_r;
    res_last_nxt   = res_last_r;
    res_miss_nxt   = res_miss_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_bits_nxt   = out_bits_r;
    out_last_nxt   = out_last_r;
    out_miss_nxt   = out_miss_r;
    in_tready      = (state_r == ST_IDLE);

    sreq.start     = 1'b0;
    sreq.ch        = in_tdata[20:13];
    sreq.dict_size = dict_size_r;
    sreq.wr_en     = 1'b0;
    sreq.wr_idx    = in_tdata[4:0];
    sreq.wr_char   = in_tdata[12:5];

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (action)
            ACT_LOAD: begin
              sreq.wr_en = ({1'b0, in_tdata[4:0]} < 6'(DICT_ENTRIES));
            end
            ACT_DATA: begin
              sreq.start = 1'b1;
              state_nxt  = ST_SEARCH;
            end
            ACT_FLUSH: begin
              res_byte_nxt = 8'(acc_r << fl_shift);
              res_bits_nxt = {1'b0, pend_r};
              res_last_nxt = 1'b1;
              res_miss_nxt = miss_r;
              acc_nxt      = '0;
              pend_nxt     = '0;
              miss_nxt     = 1'b0;
              state_nxt    = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (srsp.done) begin
          miss_nxt = miss_upd;
          if (nbits >= 4'd8) begin
            res_byte_nxt = 8'(total >> rest);
            res_bits_nxt = 4'd8;
            res_last_nxt = 1'b0;
            res_miss_nxt = miss_upd;
            acc_nxt      = 8'(total & ((13'd1 << rest) - 13'd1));
            pend_nxt     = rest;
            state_nxt    = ST_EMIT;
          end else begin
            acc_nxt   = total[7:0];
            pend_nxt  = nbits[2:0];
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_byte_nxt   = res_byte_r;
          out_bits_nxt   = res_bits_r;
          out_last_nxt   = res_last_r;
          out_miss_nxt   = res_miss_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dict_size_r  <= 6'd32;
      acc_r        <= '0;
      pend_r       <= '0;
      miss_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      pend_r       <= pend_nxt;
      miss_r       <= miss_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        dict_size_r <= cfg_wr_data;
      end
    end
    res_byte_r <= res_byte_nxt;
    res_bits_r <= res_bits_nxt;
    res_last_r <= res_last_nxt;
    res_miss_r <= res_miss_nxt;
    out_byte_r <= out_byte_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
    out_miss_r <= out_miss_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_bits_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_miss_r;

  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srsp.done |-> state_r == ST_SEARCH)
    else $error("search completion outside search state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !srsp.busy)
    else $error("input beat taken while search unit busy");

  a_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tdata[11:8] == 4'd8)
    else $error("non-final beat without a full byte");

endmodule
